/* hdl/text_window_cursor_engine_assert.svh */
// ----------------------------------------------------------------------------
// Text window cursor engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_WINDOW_CURSOR_ENGINE_ASSERT_SVH
`define TEXT_WINDOW_CURSOR_ENGINE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define TWC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define TWC_ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define TWC_ASSERT(label, prop, msg)
`define TWC_ASSERT_NEVER(label, expr, msg)

`endif

`endif

/* hdl/twc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window cursor engine package
// Types, codes and fixed constants shared by the engine's modules.
// ----------------------------------------------------------------------------
package twc_pkg;

	// Result action codes.
	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_CURSOR = 2'd2
	} twc_action_t;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WIN_LEFT   = 3'd0;
	localparam logic [2:0] CFG_WIN_TOP    = 3'd1;
	localparam logic [2:0] CFG_WIN_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_WIN_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_TEXT_ATTR  = 3'd4;

	// Control characters.
	localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
	localparam logic [7:0] CHAR_TAB       = 8'd9;
	localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
	localparam logic [7:0] CHAR_SPACE     = 8'd32;

	// Depth of the queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Window configuration as seen by the front end.
	typedef struct packed {
		logic [6:0] win_left;
		logic [4:0] win_top;
		logic [6:0] win_width;
		logic [4:0] win_height;
		logic [7:0] text_attribute;
	} twc_cfg_t;

	// One classified character, ready for the back end to expand.
	typedef struct packed {
		logic       has_write;
		logic       has_scroll;
		logic [6:0] col;
		logic [4:0] row;
		logic [7:0] chr;
		logic [7:0] attr;
		logic [6:0] cur_col;
		logic [4:0] cur_row;
	} twc_op_t;

endpackage

/* hdl/twc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window cursor engine front end
// Classifies each character, moves the cursor and builds one queue entry.
// ----------------------------------------------------------------------------
`include "text_window_cursor_engine_assert.svh"

module twc_front #(
	parameter int TAB_STOP = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  twc_pkg::twc_cfg_t cfg,
	input  logic             accept,
	input  logic [7:0]       char_code,
	output twc_pkg::twc_op_t op
);
	import twc_pkg::*;

	logic [6:0] cur_col_q;
	logic [4:0] cur_row_q;
	logic [7:0] stop_tbl [128];
	logic [6:0] iw;
	logic [4:0] ih;
	logic [6:0] col_sat;
	logic [4:0] row_sat;
	logic [7:0] stop;
	logic [6:0] col_inc;
	logic       next_line;
	logic [6:0] col_nx;
	logic [4:0] row_nx;

	// Next tab stop for every column, worked out at elaboration.
	for (genvar g = 0; g < 128; g++) begin : g_stop
		assign stop_tbl[g] = 8'(((g / TAB_STOP) + 1) * TAB_STOP);
	end

	// Interior size, with a tiny window acting as one column or one row.
	assign iw = (cfg.win_width >= 7'd2) ? cfg.win_width - 7'd1 : 7'd1;
	assign ih = (cfg.win_height >= 5'd2) ? cfg.win_height - 5'd1 : 5'd1;

	// Cursor saturates into the interior after the window shrinks.
	assign col_sat = (cur_col_q > iw - 7'd1) ? iw - 7'd1 : cur_col_q;
	assign row_sat = (cur_row_q > ih - 5'd1) ? ih - 5'd1 : cur_row_q;
	assign stop    = stop_tbl[col_sat];
	assign col_inc = col_sat + 7'd1;

	// Character decode and cursor movement.
	always_comb begin
		op.has_write  = 1'b0;
		op.has_scroll = 1'b0;
		op.col        = cfg.win_left + 7'd1 + col_sat;
		op.row        = cfg.win_top + 5'd1 + row_sat;
		op.chr        = char_code;
		op.attr       = cfg.text_attribute;
		next_line     = 1'b0;
		col_nx        = col_sat;
		row_nx        = row_sat;
		unique case (char_code)
			CHAR_TAB: begin
				next_line = (stop >= {1'b0, iw});
				col_nx    = stop[6:0];
			end
			CHAR_NEWLINE: begin
				next_line = 1'b1;
			end
			CHAR_BACKSPACE: begin
				op.has_write = 1'b1;
				op.col       = cfg.win_left + col_sat;
				op.chr       = CHAR_SPACE;
			end
			default: begin
				op.has_write = 1'b1;
				col_nx       = col_inc;
				next_line    = (col_inc >= iw);
			end
		endcase
		if (next_line) begin
			col_nx = 7'd0;
			if (row_sat >= ih - 5'd1) begin
				op.has_scroll = 1'b1;
			end else begin
				row_nx = row_sat + 5'd1;
			end
		end
		op.cur_col = col_nx;
		op.cur_row = row_nx;
	end

	// Cursor registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= 7'd0;
			cur_row_q <= 5'd0;
		end else if (accept) begin
			cur_col_q <= col_nx;
			cur_row_q <= row_nx;
		end
	end

	// The stored cursor always lands inside the interior.
	`TWC_ASSERT(a_cursor_inside, accept |=> (cur_col_q < $past(iw)) && (cur_row_q < $past(ih)), "cursor left the interior")
	// A scroll only comes from the bottom interior line.
	`TWC_ASSERT(a_scroll_bottom, op.has_scroll |-> (row_sat == ih - 5'd1) && (col_nx == 7'd0), "scroll away from bottom line")

endmodule

/* hdl/twc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window cursor engine queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "text_window_cursor_engine_assert.svh"

module twc_queue #(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  twc_pkg::twc_op_t  wr_data,
	output logic              full,
	input  logic              rd_en,
	output twc_pkg::twc_op_t  rd_data,
	output logic              q_valid
);
	import twc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	twc_op_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             wr_fire;
	logic             rd_fire;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign q_valid = (count_q != '0);
	assign wr_fire = wr_en && !full;
	assign rd_fire = rd_en && q_valid;
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_fire) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				count_q <= count_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`TWC_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count beyond depth")
	`TWC_ASSERT(a_count_up, (wr_fire && !rd_fire) |=> (count_q == $past(count_q) + 1'b1), "queue count lost a write")

endmodule

/* hdl/twc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window cursor engine back end
// Expands queue entries into one or two results and holds the output beat.
// ----------------------------------------------------------------------------
`include "text_window_cursor_engine_assert.svh"

module twc_back #(
	parameter int SCREEN_COLS = 80
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  twc_pkg::twc_op_t head,
	output logic             rd_en,
	input  logic             pop,
	output logic             empty,
	output logic [1:0]       action,
	output logic [6:0]       screen_col,
	output logic [4:0]       screen_row,
	output logic [7:0]       cell_char,
	output logic [7:0]       cell_attribute,
	output logic [11:0]      cell_address,
	output logic [6:0]       cursor_col,
	output logic [4:0]       cursor_row,
	output logic             last
);
	import twc_pkg::*;

	logic        out_valid_q;
	logic        phase_q;
	twc_action_t action_q;
	logic [6:0]  screen_col_q;
	logic [4:0]  screen_row_q;
	logic [7:0]  cell_char_q;
	logic [7:0]  cell_attribute_q;
	logic [11:0] cell_address_q;
	logic [6:0]  cursor_col_q;
	logic [4:0]  cursor_row_q;
	logic        last_q;
	logic        load;
	logic        emit_write;
	logic [10:0] lin_addr;

	// A new beat enters the output register when it is free or being taken.
	assign load       = q_valid && (!out_valid_q || pop);
	assign emit_write = head.has_write && !phase_q;
	// The entry leaves the queue with its final beat.
	assign rd_en      = load && !(emit_write && head.has_scroll);
	// Only the low bits of the cell index reach the 12-bit byte address.
	assign lin_addr   = 11'(20'(head.row) * 20'(SCREEN_COLS) + 20'(head.col));

	// Control: output valid and the write-then-scroll phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= emit_write && head.has_scroll;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			cursor_col_q <= head.cur_col;
			cursor_row_q <= head.cur_row;
			if (emit_write) begin
				action_q         <= ACT_WRITE;
				screen_col_q     <= head.col;
				screen_row_q     <= head.row;
				cell_char_q      <= head.chr;
				cell_attribute_q <= head.attr;
				cell_address_q   <= {lin_addr, 1'b0};
				last_q           <= !head.has_scroll;
			end else begin
				action_q         <= head.has_scroll ? ACT_SCROLL : ACT_CURSOR;
				screen_col_q     <= 7'd0;
				screen_row_q     <= 5'd0;
				cell_char_q      <= 8'd0;
				cell_attribute_q <= 8'd0;
				cell_address_q   <= 12'd0;
				last_q           <= 1'b1;
			end
		end
	end

	assign empty          = !out_valid_q;
	assign action         = action_q;
	assign screen_col     = screen_col_q;
	assign screen_row     = screen_row_q;
	assign cell_char      = cell_char_q;
	assign cell_attribute = cell_attribute_q;
	assign cell_address   = cell_address_q;
	assign cursor_col     = cursor_col_q;
	assign cursor_row     = cursor_row_q;
	assign last           = last_q;

	// The scroll phase only exists for an entry that writes and then scrolls.
	`TWC_ASSERT(a_phase_entry, phase_q |-> (q_valid && head.has_write && head.has_scroll), "scroll phase without its entry")
	// Only a write beat can be followed by another beat of the same character.
	`TWC_ASSERT(a_not_last_write, (out_valid_q && !last_q) |-> (action_q == ACT_WRITE), "non-final beat is not a write")

endmodule

/* hdl/text_window_cursor_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text window cursor engine
// Keeps a cursor in a framed text window and turns characters into cell
// writes, scrolls and cursor updates.
// ----------------------------------------------------------------------------
// One character is accepted per clock while the four-entry queue between the
// front end and the back end has room. The front end decodes the character
// and moves the cursor in the cycle it is accepted; the back end hands out one
// result beat per cycle from its output register while the consumer pops. Each
// result is registered in the queue, then in the output register. A printable
// character that wraps on the bottom line takes two beats (write, then scroll);
// every other character takes one. The single output register port thus sets
// the sustained rate: one character per cycle while beats are popped and each
// takes one beat. Configuration writes are always taken (ready stays high).

module text_window_cursor_engine #(
	parameter int SCREEN_COLS = 80,
	parameter int TAB_STOP    = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  action,
	output logic [6:0]  screen_col,
	output logic [4:0]  screen_row,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_attribute,
	output logic [11:0] cell_address,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import twc_pkg::*;

	twc_cfg_t cfg_q;
	twc_op_t  front_op;
	twc_op_t  head_op;
	logic     accept;
	logic     q_valid;
	logic     rd_en;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.win_left       <= 7'd0;
			cfg_q.win_top        <= 5'd0;
			cfg_q.win_width      <= 7'd80;
			cfg_q.win_height     <= 5'd25;
			cfg_q.text_attribute <= 8'd7;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WIN_LEFT:   cfg_q.win_left       <= cfg_data[6:0];
				CFG_WIN_TOP:    cfg_q.win_top        <= cfg_data[4:0];
				CFG_WIN_WIDTH:  cfg_q.win_width      <= cfg_data[6:0];
				CFG_WIN_HEIGHT: cfg_q.win_height     <= cfg_data[4:0];
				CFG_TEXT_ATTR:  cfg_q.text_attribute <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Front end: decode and cursor movement.
	twc_front #(
		.TAB_STOP(TAB_STOP)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.accept   (accept),
		.char_code(char_code),
		.op       (front_op)
	);

	// Queue between the two halves.
	twc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push),
		.wr_data(front_op),
		.full   (full),
		.rd_en  (rd_en),
		.rd_data(head_op),
		.q_valid(q_valid)
	);

	// Back end: result beats.
	twc_back #(
		.SCREEN_COLS(SCREEN_COLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.head          (head_op),
		.rd_en         (rd_en),
		.pop           (pop),
		.empty         (empty),
		.action        (action),
		.screen_col    (screen_col),
		.screen_row    (screen_row),
		.cell_char     (cell_char),
		.cell_attribute(cell_attribute),
		.cell_address  (cell_address),
		.cursor_col    (cursor_col),
		.cursor_row    (cursor_row),
		.last          (last)
	);

endmodule
